// File: hw/rtl/usp_pkg.sv
// Shared types and constants for the UDP session permit filter.
// Used by the front, queue, back and top-level modules; no dependencies.
package usp_pkg;

  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = 2;

  localparam logic [15:0] PORT_RESET  = 16'd9999;
  localparam logic [15:0] ETHER_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] HDR_ETH     = 16'd14;
  localparam logic [15:0] HDR_IP_MIN  = 16'd34;
  localparam logic [15:0] HDR_UDP     = 16'd8;
  localparam logic [15:0] PAYLOAD_MIN = 16'd11;
  localparam logic [15:0] KEY_OFFSET  = 16'd3;
  localparam logic [15:0] KEY_BYTES   = 16'd8;

  // Input commands
  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // Queue job codes
  localparam logic [1:0] OP_VERDICT = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_ADD     = 2'd2;
  localparam logic [1:0] OP_REMOVE  = 2'd3;

  // Verdict causes
  localparam logic [1:0] CAUSE_OTHER     = 2'd0;
  localparam logic [1:0] CAUSE_PERMITTED = 2'd1;
  localparam logic [1:0] CAUSE_SHORT     = 2'd2;
  localparam logic [1:0] CAUSE_NO_PERMIT = 2'd3;

  // Table status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_TABLE   = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [63:0] permit_key;
  } usp_in_t;

  typedef struct packed {
    logic        result_kind;
    logic        verdict;
    logic [1:0]  verdict_cause;
    logic [1:0]  table_status;
    logic [31:0] drops_counted;
  } usp_out_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  cause;
    logic [63:0] key;
  } usp_job_t;

endpackage

// File: hw/rtl/udp_session_permit_filter.sv
// Results: a verdict for an unfiltered, short or unchecked frame is registered
// from the queue head without a table search; lookups, adds and removes scan
// the table at one entry per cycle through one memory read port.
// Frame bytes are taken every cycle while the 4-entry job queue has room and
// no clearing pass runs. Reset: a clearing pass over all TABLE_ENTRIES entries
// holds busy high; results cannot be stalled by the receiver.
module udp_session_permit_filter #(
  parameter int unsigned TABLE_ENTRIES = usp_pkg::TABLE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  usp_pkg::usp_in_t  req,
  output logic              result_strobe,
  output usp_pkg::usp_out_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic              accept;
  logic              push;
  logic              pop;
  logic              empty;
  logic              full;
  logic              clearing;
  logic [15:0]       filter_port;
  usp_pkg::usp_job_t push_job;
  usp_pkg::usp_job_t head;

  assign busy   = full || clearing;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, filter_port} : 32'd0;

  // Register write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_port <= usp_pkg::PORT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      filter_port <= pwdata[15:0];
    end
  end

  usp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req         (req),
    .filter_port (filter_port),
    .push        (push),
    .job         (push_job)
  );

  usp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  usp_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .head          (head),
    .pop           (pop),
    .clearing      (clearing),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

// File: hw/rtl/usp_front.sv
// Front end: parses frame bytes, classifies finished frames, queues jobs.
// Depends on usp_pkg.
module usp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  usp_pkg::usp_in_t  req,
  input  logic [15:0]       filter_port,
  output logic              push,
  output usp_pkg::usp_job_t job
);

  logic [15:0] byte_position;
  logic [15:0] ether_kind;
  logic [7:0]  ip_protocol_seen;
  logic [6:0]  udp_start;
  logic [15:0] dest_port_seen;
  logic [63:0] session_gather;

  logic [15:0] ether_next;
  logic [7:0]  proto_next;
  logic [6:0]  udp_next;
  logic [15:0] port_next;
  logic [63:0] gather_next;
  logic [15:0] pos_next;
  logic [15:0] u_old;
  logic [15:0] u_new;
  logic [15:0] len;
  logic [1:0]  cause;
  logic        need_lookup;
  logic        is_byte;

  // Capture header fields from the current byte
  always_comb begin
    u_old       = {9'd0, udp_start};
    ether_next  = ether_kind;
    proto_next  = ip_protocol_seen;
    udp_next    = udp_start;
    port_next   = dest_port_seen;
    gather_next = session_gather;
    if (byte_position == 16'd12) ether_next = {req.data_byte, ether_kind[7:0]};
    if (byte_position == 16'd13) ether_next = {ether_kind[15:8], req.data_byte};
    if (byte_position == 16'd14) udp_next = 7'd14 + {1'b0, req.data_byte[3:0], 2'b00};
    if (byte_position == 16'd23) proto_next = req.data_byte;
    if (byte_position == u_old + 16'd2) port_next = {req.data_byte, dest_port_seen[7:0]};
    if (byte_position == u_old + 16'd3) port_next = {dest_port_seen[15:8], req.data_byte};
    if (byte_position >= u_old + usp_pkg::HDR_UDP + usp_pkg::KEY_OFFSET &&
        byte_position < u_old + usp_pkg::HDR_UDP + usp_pkg::KEY_OFFSET + usp_pkg::KEY_BYTES)
      gather_next = {session_gather[55:0], req.data_byte};
    pos_next = (byte_position == 16'hFFFF) ? byte_position : byte_position + 16'd1;
    len      = pos_next;
  end

  // Classify a finished frame ahead of the table lookup
  always_comb begin
    u_new       = {9'd0, udp_next};
    cause       = usp_pkg::CAUSE_OTHER;
    need_lookup = 1'b0;
    if (len < usp_pkg::HDR_ETH) cause = usp_pkg::CAUSE_OTHER;
    else if (ether_next != usp_pkg::ETHER_IPV4) cause = usp_pkg::CAUSE_OTHER;
    else if (len < usp_pkg::HDR_IP_MIN) cause = usp_pkg::CAUSE_OTHER;
    else if (proto_next != usp_pkg::PROTO_UDP) cause = usp_pkg::CAUSE_OTHER;
    else if (len < u_new + usp_pkg::HDR_UDP) cause = usp_pkg::CAUSE_OTHER;
    else if (port_next != filter_port) cause = usp_pkg::CAUSE_OTHER;
    else if (len < u_new + usp_pkg::HDR_UDP + usp_pkg::PAYLOAD_MIN)
      cause = usp_pkg::CAUSE_SHORT;
    else need_lookup = 1'b1;
  end

  // Build the queue job
  always_comb begin
    is_byte = (req.command == usp_pkg::CMD_BYTE);
    push    = 1'b0;
    job     = '{op: usp_pkg::OP_VERDICT, cause: cause, key: req.permit_key};
    case (req.command)
      usp_pkg::CMD_BYTE: begin
        push    = accept && req.last_byte;
        job.op  = need_lookup ? usp_pkg::OP_LOOKUP : usp_pkg::OP_VERDICT;
        job.key = gather_next;
      end
      usp_pkg::CMD_ADD: begin
        push   = accept;
        job.op = usp_pkg::OP_ADD;
      end
      usp_pkg::CMD_REMOVE: begin
        push   = accept;
        job.op = usp_pkg::OP_REMOVE;
      end
      default: push = 1'b0;
    endcase
  end

  // Advance frame state; clear it after each verdict
  always_ff @(posedge clk) begin
    if (rst || (accept && is_byte && req.last_byte)) begin
      byte_position    <= '0;
      ether_kind       <= '0;
      ip_protocol_seen <= '0;
      udp_start        <= 7'd14;
      dest_port_seen   <= '0;
      session_gather   <= '0;
    end else if (accept && is_byte) begin
      byte_position    <= pos_next;
      ether_kind       <= ether_next;
      ip_protocol_seen <= proto_next;
      udp_start        <= udp_next;
      dest_port_seen   <= port_next;
      session_gather   <= gather_next;
    end
  end

endmodule

// File: hw/rtl/usp_queue.sv
// Short job queue between the front and back ends.
// Depends on usp_pkg.
module usp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  usp_pkg::usp_job_t push_job,
  input  logic              pop,
  output usp_pkg::usp_job_t head,
  output logic              empty,
  output logic              full
);

  usp_pkg::usp_job_t                    slots [usp_pkg::QUEUE_DEPTH];
  logic [usp_pkg::QPTR_W-1:0]           wr_ptr;
  logic [usp_pkg::QPTR_W-1:0]           rd_ptr;
  logic [usp_pkg::QPTR_W:0]             count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == (usp_pkg::QPTR_W+1)'(usp_pkg::QUEUE_DEPTH));

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/usp_back.sv
// Back end: permit table memory, sequential search, drop counter, results.
// Depends on usp_pkg.
module usp_back #(
  parameter int unsigned TABLE_ENTRIES = usp_pkg::TABLE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  usp_pkg::usp_job_t head,
  output logic              pop,
  output logic              clearing,
  output logic              result_strobe,
  output usp_pkg::usp_out_t result
);

  localparam int unsigned IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned LAST_IDX = TABLE_ENTRIES - 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
  } entry_t;

  entry_t            mem [TABLE_ENTRIES];
  entry_t            rd_data;
  entry_t            wr_data;
  logic [IDX_W-1:0]  wr_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  rd_addr;

  state_t            state;
  usp_pkg::usp_job_t job;
  logic [IDX_W-1:0]  clr_idx;
  logic [IDX_W:0]    issue;
  logic              issue_ok;
  logic              cmp_vld;
  logic [IDX_W-1:0]  cmp_idx;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic              free_seen;
  logic [IDX_W-1:0]  free_idx;
  logic [31:0]       drop_total;
  logic [31:0]       drop_inc;
  logic              hit;
  usp_pkg::usp_out_t done_res;

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && !empty;
  assign rd_addr  = issue[IDX_W-1:0];
  assign issue_ok = (state == S_SCAN) && (issue < (IDX_W+1)'(TABLE_ENTRIES));
  assign hit      = cmp_vld && rd_data.valid && (rd_data.key == job.key);
  assign drop_inc = (drop_total != 32'hFFFF_FFFF) ? drop_total + 32'd1 : drop_total;

  // Select the memory write
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_idx;
    wr_data = '0;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
    end else if (state == S_DONE) begin
      if (job.op == usp_pkg::OP_ADD && !found && free_seen) begin
        wr_en   = 1'b1;
        wr_addr = free_idx;
        wr_data = '{valid: 1'b1, key: job.key};
      end else if (job.op == usp_pkg::OP_REMOVE && found) begin
        wr_en   = 1'b1;
        wr_addr = found_idx;
      end
    end
  end

  // Table memory, registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Form the result of a finished search job
  always_comb begin
    done_res = '{result_kind: usp_pkg::KIND_TABLE, verdict: 1'b0,
                 verdict_cause: usp_pkg::CAUSE_OTHER, table_status: usp_pkg::ST_OK,
                 drops_counted: drop_total};
    case (job.op)
      usp_pkg::OP_LOOKUP: begin
        done_res.result_kind = usp_pkg::KIND_VERDICT;
        if (found) begin
          done_res.verdict_cause = usp_pkg::CAUSE_PERMITTED;
        end else begin
          done_res.verdict       = 1'b1;
          done_res.verdict_cause = usp_pkg::CAUSE_NO_PERMIT;
          done_res.drops_counted = drop_inc;
        end
      end
      usp_pkg::OP_ADD: begin
        if (!found && !free_seen) done_res.table_status = usp_pkg::ST_FULL;
      end
      usp_pkg::OP_REMOVE: begin
        if (!found) done_res.table_status = usp_pkg::ST_NOT_FOUND;
      end
      default: done_res.table_status = usp_pkg::ST_OK;
    endcase
  end

  // Sequence jobs and drive results
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      result_strobe <= 1'b0;
      drop_total    <= '0;
      cmp_vld       <= 1'b0;
      issue         <= '0;
    end else begin
      result_strobe <= (state == S_DONE) ||
                       ((state == S_IDLE) && !empty && (head.op == usp_pkg::OP_VERDICT));
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_W'(LAST_IDX)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (!empty) begin
            job       <= head;
            issue     <= '0;
            cmp_vld   <= 1'b0;
            found     <= 1'b0;
            free_seen <= 1'b0;
            if (head.op == usp_pkg::OP_VERDICT) begin
              result <= '{result_kind: usp_pkg::KIND_VERDICT,
                          verdict: (head.cause == usp_pkg::CAUSE_SHORT),
                          verdict_cause: head.cause,
                          table_status: usp_pkg::ST_OK,
                          drops_counted: drop_total};
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue_ok) issue <= issue + 1'b1;
          cmp_vld <= issue_ok && !hit;
          cmp_idx <= rd_addr;
          if (hit) begin
            found     <= 1'b1;
            found_idx <= cmp_idx;
            state     <= S_DONE;
          end else if (cmp_vld) begin
            if (!rd_data.valid && !free_seen) begin
              free_seen <= 1'b1;
              free_idx  <= cmp_idx;
            end
            if (cmp_idx == IDX_W'(LAST_IDX)) state <= S_DONE;
          end
        end
        S_DONE: begin
          state  <= S_IDLE;
          result <= done_res;
          if (job.op == usp_pkg::OP_LOOKUP && !found) drop_total <= drop_inc;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: verif/tb_udp_session_permit_filter.sv
// Self-checking testbench for udp_session_permit_filter: directed table, random frames
// and table commands under several APB filter port settings.
// Depends on usp_pkg and the udp_session_permit_filter RTL.
module tb_udp_session_permit_filter;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  usp_pkg::usp_in_t  req = '0;
  logic              result_strobe;
  usp_pkg::usp_out_t result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  localparam logic [2:0] ADDR_FILTER_PORT = 3'd0;
  localparam logic [1:0] CMD_IGNORED      = 2'd3;

  udp_session_permit_filter dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .result_strobe(result_strobe), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  initial begin
    #100_000_000;
    $display("udp_session_permit_filter regression: fail");
    $finish;
  end

  // Filter model state
  logic [15:0] port_cfg;
  logic [15:0] pos_q;
  logic [15:0] ether_q;
  logic [7:0]  proto_q;
  int unsigned udp_q;
  logic [15:0] dport_q;
  logic [63:0] gather_q;
  logic [63:0] permit_key_mem [usp_pkg::TABLE_ENTRIES];
  bit          permit_live [usp_pkg::TABLE_ENTRIES];
  logic [31:0] drop_cnt;
  logic [63:0] live_keys[$];

  usp_pkg::usp_out_t expected_results[$];
  int       errors = 0;
  int       items_sent = 0;
  bit       no_idle = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int find_permit(input logic [63:0] k);
    for (int i = 0; i < usp_pkg::TABLE_ENTRIES; i++)
      if (permit_live[i] && permit_key_mem[i] == k) return i;
    return -1;
  endfunction

  task automatic clear_frame();
    pos_q = '0; ether_q = '0; proto_q = '0; udp_q = 14; dport_q = '0; gather_q = '0;
  endtask

  function automatic logic [1:0] classify_frame(input int unsigned len);
    if (len < 14 || ether_q != usp_pkg::ETHER_IPV4 || len < 34 ||
        proto_q != usp_pkg::PROTO_UDP) return usp_pkg::CAUSE_OTHER;
    if (len < udp_q + 8 || dport_q != port_cfg) return usp_pkg::CAUSE_OTHER;
    if (len < udp_q + 19) return usp_pkg::CAUSE_SHORT;
    if (find_permit(gather_q) >= 0) return usp_pkg::CAUSE_PERMITTED;
    return usp_pkg::CAUSE_NO_PERMIT;
  endfunction

  // Advance the model by one accepted transfer; return any result it causes.
  task automatic predict_item(input usp_pkg::usp_in_t it, output bit has_res,
                              output usp_pkg::usp_out_t res);
    int unsigned p;
    int idx;
    res = '0;
    has_res = 1'b0;
    if (it.command == usp_pkg::CMD_BYTE) begin
      p = {16'd0, pos_q};
      if (p == 12) ether_q[15:8] = it.data_byte;
      if (p == 13) ether_q[7:0] = it.data_byte;
      if (p == 14) udp_q = 14 + 4 * it.data_byte[3:0];
      if (p == 23) proto_q = it.data_byte;
      if (p == udp_q + 2) dport_q[15:8] = it.data_byte;
      if (p == udp_q + 3) dport_q[7:0] = it.data_byte;
      if (p >= udp_q + 11 && p < udp_q + 19) gather_q = {gather_q[55:0], it.data_byte};
      if (pos_q != 16'hFFFF) pos_q++;
      if (!it.last_byte) return;
      res.result_kind = usp_pkg::KIND_VERDICT;
      res.verdict_cause = classify_frame((p < 32'hFFFF) ? p + 1 : 32'hFFFF);
      if (res.verdict_cause == usp_pkg::CAUSE_NO_PERMIT && drop_cnt != 32'hFFFF_FFFF)
        drop_cnt++;
      res.verdict = (res.verdict_cause >= usp_pkg::CAUSE_SHORT);
      res.drops_counted = drop_cnt;
      clear_frame();
      has_res = 1'b1;
      return;
    end
    if (it.command == CMD_IGNORED) return;
    has_res = 1'b1;
    res.result_kind = usp_pkg::KIND_TABLE;
    res.drops_counted = drop_cnt;
    idx = find_permit(it.permit_key);
    if (it.command == usp_pkg::CMD_ADD) begin
      res.table_status = usp_pkg::ST_OK;
      if (idx >= 0) return;
      res.table_status = usp_pkg::ST_FULL;
      for (int i = 0; i < usp_pkg::TABLE_ENTRIES; i++)
        if (!permit_live[i]) begin
          permit_live[i] = 1'b1;
          permit_key_mem[i] = it.permit_key;
          live_keys.push_back(it.permit_key);
          res.table_status = usp_pkg::ST_OK;
          break;
        end
    end else if (idx >= 0) begin
      permit_live[idx] = 1'b0;
      foreach (live_keys[j])
        if (live_keys[j] == it.permit_key) begin
          live_keys.delete(j);
          break;
        end
      res.table_status = usp_pkg::ST_OK;
    end else begin
      res.table_status = usp_pkg::ST_NOT_FOUND;
    end
  endtask

  // Hold start until the transfer is taken, then predict and maybe idle.
  task automatic drive_item(input usp_pkg::usp_in_t it, input bit typed,
                            input usp_pkg::usp_out_t typed_res);
    bit has_res;
    usp_pkg::usp_out_t res;
    start <= 1'b1;
    req <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    predict_item(it, has_res, res);
    if (typed) expected_results.push_back(typed_res);
    else if (has_res) expected_results.push_back(res);
    if (!no_idle && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Check each strobed result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", 64'(result), 64'd0);
      end else begin
        usp_pkg::usp_out_t w;
        w = expected_results.pop_front();
        if (result.result_kind !== w.result_kind)
          report("result_kind", 64'(result.result_kind), 64'(w.result_kind));
        if (result.verdict !== w.verdict)
          report("verdict", 64'(result.verdict), 64'(w.verdict));
        if (result.verdict_cause !== w.verdict_cause)
          report("verdict_cause", 64'(result.verdict_cause), 64'(w.verdict_cause));
        if (result.table_status !== w.table_status)
          report("table_status", 64'(result.table_status), 64'(w.table_status));
        if (result.drops_counted !== w.drops_counted)
          report("drops_counted", 64'(result.drops_counted), 64'(w.drops_counted));
      end
    end
  end

  task automatic drain();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (usp_pkg::TABLE_ENTRIES + 16) @(posedge clk);
  endtask

  // Write the filter port, then read it back.
  task automatic set_port(input logic [15:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_FILTER_PORT;
    pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    port_cfg = v;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== v) report("filter_port readback", 64'(prdata[15:0]), 64'(v));
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_key();
    if (live_keys.size() != 0 && $urandom_range(99) < 60)
      return live_keys[$urandom_range(live_keys.size() - 1)];
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic usp_pkg::usp_in_t rand_command();
    usp_pkg::usp_in_t it;
    it.command = ($urandom_range(19) == 0) ? CMD_IGNORED :
                 ($urandom_range(1) ? usp_pkg::CMD_ADD : usp_pkg::CMD_REMOVE);
    it.data_byte = 8'($urandom);
    it.last_byte = 1'($urandom);
    it.permit_key = pick_key();
    return it;
  endfunction

  // Send one frame: mostly a well-formed UDP frame aimed at the filter port.
  task automatic send_frame(input int force_len);
    int unsigned nib, u, len, mode;
    logic [7:0] fb[$];
    logic [63:0] k;
    usp_pkg::usp_in_t it;
    nib = ($urandom_range(9) < 7) ? 5 : $urandom_range(15);
    u = 14 + 4 * nib;
    mode = $urandom_range(9);
    if (force_len > 0) len = force_len;
    else if (mode <= 5) len = u + 19 + $urandom_range(4);
    else if (mode <= 7) len = $urandom_range(u + 8, u + 18);
    else if (mode == 8) len = $urandom_range(1, 40);
    else len = $urandom_range(u + 19, u + 100);
    k = pick_key();
    for (int i = 0; i < len; i++) fb.push_back(8'($urandom));
    if ($urandom_range(19) != 0) begin
      if ($urandom_range(9) != 0) begin
        if (len > 12) fb[12] = 8'h08;
        if (len > 13) fb[13] = 8'h00;
      end
      if (len > 14) fb[14] = {fb[14][7:4], nib[3:0]};
      if (len > 23 && $urandom_range(9) != 0) fb[23] = usp_pkg::PROTO_UDP;
      if ($urandom_range(99) < 85) begin
        if (len > u + 2) fb[u + 2] = port_cfg[15:8];
        if (len > u + 3) fb[u + 3] = port_cfg[7:0];
      end
      for (int j = 0; j < 8; j++)
        if (len > u + 11 + j) fb[u + 11 + j] = k[63 - 8 * j -: 8];
    end
    for (int i = 0; i < len; i++) begin
      if (force_len == 0 && $urandom_range(99) < 4) drive_item(rand_command(), 1'b0, '0);
      it.command = usp_pkg::CMD_BYTE;
      it.data_byte = fb[i];
      it.last_byte = (i == len - 1);
      it.permit_key = {$urandom, $urandom};
      drive_item(it, 1'b0, '0);
    end
  endtask

  task automatic random_phase(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 8) send_frame(0);
      else drive_item(rand_command(), 1'b0, '0);
    end
  endtask

  typedef struct {
    usp_pkg::usp_in_t  it;
    bit                typed;
    usp_pkg::usp_out_t res;
  } stim_row_t;

  function automatic stim_row_t row(input logic [1:0] cmd, input logic [7:0] b, input logic l,
                                    input logic [63:0] k, input bit typed,
                                    input usp_pkg::usp_out_t r);
    stim_row_t s;
    s.it.command = cmd; s.it.data_byte = b; s.it.last_byte = l; s.it.permit_key = k;
    s.typed = typed; s.res = r;
    return s;
  endfunction

  initial begin
    stim_row_t rows[$];
    usp_pkg::usp_out_t tbl_ok, tbl_missing, pass_other;
    tbl_ok = '{result_kind: usp_pkg::KIND_TABLE, verdict: 1'b0,
               verdict_cause: usp_pkg::CAUSE_OTHER,
               table_status: usp_pkg::ST_OK, drops_counted: 32'd0};
    tbl_missing = tbl_ok;
    tbl_missing.table_status = usp_pkg::ST_NOT_FOUND;
    pass_other = '{result_kind: usp_pkg::KIND_VERDICT, verdict: 1'b0,
                   verdict_cause: usp_pkg::CAUSE_OTHER,
                   table_status: usp_pkg::ST_OK, drops_counted: 32'd0};

    port_cfg = usp_pkg::PORT_RESET;
    drop_cnt = '0;
    clear_frame();
    foreach (permit_live[i]) permit_live[i] = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table: extremes, every command, duplicates, ignored code.
    rows.push_back(row(usp_pkg::CMD_ADD, 8'hFF, 1'b1, 64'h0, 1'b1, tbl_ok));
    rows.push_back(row(usp_pkg::CMD_ADD, 8'h00, 1'b0, '1, 1'b1, tbl_ok));
    rows.push_back(row(usp_pkg::CMD_ADD, 8'h5A, 1'b1, '1, 1'b1, tbl_ok));
    rows.push_back(row(usp_pkg::CMD_REMOVE, 8'h00, 1'b0, 64'h1234, 1'b1, tbl_missing));
    rows.push_back(row(usp_pkg::CMD_REMOVE, 8'hFF, 1'b1, '1, 1'b1, tbl_ok));
    rows.push_back(row(usp_pkg::CMD_REMOVE, 8'hFF, 1'b1, '1, 1'b1, tbl_missing));
    rows.push_back(row(CMD_IGNORED, 8'hFF, 1'b1, '1, 1'b0, '0));
    rows.push_back(row(usp_pkg::CMD_BYTE, 8'hFF, 1'b1, '1, 1'b1, pass_other));
    rows.push_back(row(usp_pkg::CMD_BYTE, 8'h00, 1'b1, 64'h0, 1'b1, pass_other));
    rows.push_back(row(usp_pkg::CMD_BYTE, 8'h08, 1'b0, 64'h0, 1'b0, '0));
    rows.push_back(row(usp_pkg::CMD_ADD, 8'h00, 1'b0, 64'h0123_4567_89AB_CDEF, 1'b0, '0));
    rows.push_back(row(usp_pkg::CMD_BYTE, 8'h00, 1'b1, 64'h0, 1'b1, pass_other));
    rows.push_back(row(usp_pkg::CMD_REMOVE, 8'h00, 1'b0, 64'h0, 1'b1, tbl_ok));
    foreach (rows[i]) drive_item(rows[i].it, rows[i].typed, rows[i].res);

    // Random traffic under several filter port settings.
    random_phase(140);
    drain();
    set_port(16'd0);
    random_phase(140);
    drain();
    set_port(16'hFFFF);
    no_idle = 1'b1;
    random_phase(140);
    no_idle = 1'b0;
    drain();
    set_port(16'($urandom));
    random_phase(140);

    drain();
    if (errors == 0) begin
      $display("udp_session_permit_filter regression: pass");
    end else begin
      $display("udp_session_permit_filter regression: fail");
    end
    $finish;
  end

endmodule
